[hdl/assert_macros.svh]
// assertion macros used by the regulator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: invariant");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

`endif

[hdl/blpr_pkg.sv]
// types and constants of the boost load pwm regulator
`default_nettype none

package blpr_pkg;

  // opcodes of an input beat
  localparam logic [1:0] OPC_TICK    = 2'd0;
  localparam logic [1:0] OPC_ENABLE  = 2'd1;
  localparam logic [1:0] OPC_DISABLE = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_CURRENT_LIMIT  = 2'd0;
  localparam logic [1:0] REG_NOMINAL_TARGET = 2'd1;
  localparam logic [1:0] REG_MAX_DUTY       = 2'd2;

  // configuration reset values
  localparam logic [14:0] LIMIT_RESET   = 15'd3000;
  localparam logic [14:0] NOMINAL_RESET = 15'd5000;
  localparam logic [19:0] MAXDUTY_RESET = 20'd900000;

  // control loop constants
  localparam logic [14:0] TARGET_STEP = 15'd20;
  localparam logic [21:0] POWER_GAIN  = 22'd30;
  localparam logic [7:0]  CMP_TOP     = 8'd160;
  localparam logic [7:0]  CMP_TOP_AUX = 8'd161;

  // ceil(2^27 / 50): exact quotient for magnitudes below 2^21
  localparam logic [21:0] RECIP_50   = 22'd2684355;
  // ceil(2^31 / 3125): exact quotient of (duty >> 1) / 3125 below 2^19
  localparam logic [19:0] RECIP_3125 = 20'd687195;

  // input beat held in the input register
  typedef struct packed {
    logic [1:0]         opcode;
    logic [14:0]        load_current_ma;
    logic [14:0]        load_voltage_mv;
    logic [17:0]        load_power_mw;
    logic signed [15:0] batt_current_ma;
    logic [14:0]        max_discharge_ma;
  } in_beat_t;

  // state after one item, held in the result register
  typedef struct packed {
    logic        enabled;
    logic        tripped;
    logic [19:0] duty;
    logic [14:0] target;
    logic        cmp_live;
  } res_beat_t;

endpackage

`default_nettype wire

[hdl/boost_load_pwm_regulator.sv]
// boost load pwm regulator: cascaded voltage and power loop with compare outputs
//
// Input channel (in_valid/in_ready) carries one beat per control event: a
// tick with load current, voltage, power and battery figures, an enable or
// a disable. Every input beat yields exactly one output beat
// (out_valid/out_ready) with the run flag, trip flag, duty accumulator,
// voltage target and the two timer compare values after that event.
// Path: input register, result register, output register. Throughput: one
// beat per cycle unless the receiver stalls the output; the state update of the
// regulator (target step, power error, divide by 50, duty clamp) completes
// in the single stage after the input register, so the next beat sees it.
// The compare values are derived from the duty in the output stage.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 current
// limit, 1 nominal target, 2 duty clamp); write only while the block is idle.
// Reset (rst, synchronous): block disabled, duty 0, target and registers at
// their defaults, pipeline empty; the output data registers are not reset.
// A stalled receiver holds the output beat; the stages behind it fill and
// in_ready drops once all three are occupied.
`default_nettype none

module boost_load_pwm_regulator
  import blpr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration write port
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [19:0]        cfg_data,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         opcode,
  input  wire logic [14:0]        load_current_ma,
  input  wire logic [14:0]        load_voltage_mv,
  input  wire logic [17:0]        load_power_mw,
  input  wire logic signed [15:0] batt_current_ma,
  input  wire logic [14:0]        max_discharge_ma,
  // output channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    enabled,
  output logic                    tripped,
  output logic [19:0]             duty_scaled,
  output logic [14:0]             target_mv,
  output logic [7:0]              compare_main,
  output logic [7:0]              compare_aux
);

`include "assert_macros.svh"

  // configuration registers
  logic [14:0] current_limit_ma;
  logic [14:0] nominal_target_mv;
  logic [19:0] max_duty_scaled;

  // regulator state
  logic        run_flag;
  logic [19:0] duty_acc;
  logic [14:0] volt_target;
  logic        cmp_live;

  // pipeline registers
  logic      v1;
  in_beat_t  s1;
  logic      v2;
  res_beat_t s2;
  logic      v3;

  // pipeline flow
  logic adv2, adv3, go2;

  // state update signals
  logic               run_next;
  logic               trip_next;
  logic [19:0]        duty_next;
  logic [14:0]        target_next;
  logic               live_next;
  logic signed [16:0] batt_neg;
  logic               over_discharge;
  logic [14:0]        tgt_upd;
  logic [21:0]        t30;
  logic [21:0]        c_term;
  logic signed [21:0] err;
  logic [21:0]        err_abs;
  logic [20:0]        err_mag;
  logic [42:0]        prod50;
  logic [14:0]        q50;
  logic [20:0]        duty_sum;
  logic [19:0]        duty_upd;

  // compare stage signals
  logic [38:0] prod_cmp;
  logic [7:0]  q_cmp;
  logic [7:0]  cmp_main_next;
  logic [7:0]  cmp_aux_next;
  logic        cmp_pair_ok;

  // configuration writes, out-of-range index ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      current_limit_ma  <= LIMIT_RESET;
      nominal_target_mv <= NOMINAL_RESET;
      max_duty_scaled   <= MAXDUTY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CURRENT_LIMIT:  current_limit_ma  <= cfg_data[14:0];
        REG_NOMINAL_TARGET: nominal_target_mv <= cfg_data[14:0];
        REG_MAX_DUTY:       max_duty_scaled   <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake: each stage moves when the one ahead is empty or moving
  assign adv3     = !v3 || out_ready;
  assign adv2     = !v2 || adv3;
  assign in_ready = !v1 || adv2;
  assign go2      = v1 && adv2;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (in_ready) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1.opcode           <= opcode;
      s1.load_current_ma  <= load_current_ma;
      s1.load_voltage_mv  <= load_voltage_mv;
      s1.load_power_mw    <= load_power_mw;
      s1.batt_current_ma  <= batt_current_ma;
      s1.max_discharge_ma <= max_discharge_ma;
    end
  end

  // voltage target: step down on heavy discharge, else creep up toward nominal
  assign batt_neg = -($signed({s1.batt_current_ma[15], s1.batt_current_ma}));
  assign over_discharge = batt_neg >= $signed({2'b00, s1.max_discharge_ma});

  always_comb begin
    if (over_discharge) begin
      tgt_upd = (volt_target >= TARGET_STEP) ? (volt_target - TARGET_STEP) : '0;
    end else if (volt_target < nominal_target_mv) begin
      tgt_upd = volt_target + 15'd1;
    end else begin
      tgt_upd = volt_target;
    end
  end

  // power error = (target - voltage) * 30 - power
  assign t30     = 22'(tgt_upd) * POWER_GAIN;
  assign c_term  = 22'(s1.load_voltage_mv) * POWER_GAIN + 22'(s1.load_power_mw);
  assign err     = $signed(t30 - c_term);
  assign err_abs = err[21] ? 22'(-err) : 22'(err);
  assign err_mag = err_abs[20:0];

  // magnitude / 50 by reciprocal, sign restored below (truncates toward zero)
  assign prod50 = 43'(err_mag) * 43'(RECIP_50);
  assign q50    = prod50[41:27];

  // duty accumulate, zero when below the negated error, then clamp
  always_comb begin
    if (err[21] && (21'(duty_acc) < err_mag)) begin
      duty_sum = '0;
    end else if (err[21]) begin
      duty_sum = 21'(duty_acc) - 21'(q50);
    end else begin
      duty_sum = 21'(duty_acc) + 21'(q50);
    end
  end

  assign duty_upd = (duty_sum > 21'(max_duty_scaled)) ? max_duty_scaled : duty_sum[19:0];

  // next state by opcode
  always_comb begin
    run_next    = run_flag;
    trip_next   = 1'b0;
    duty_next   = duty_acc;
    target_next = volt_target;
    live_next   = cmp_live;
    case (s1.opcode)
      OPC_ENABLE: begin
        run_next  = 1'b1;
        duty_next = '0;
        live_next = 1'b0;
      end
      OPC_DISABLE: begin
        run_next = 1'b0;
      end
      OPC_TICK: begin
        if (run_flag) begin
          if (s1.load_current_ma > current_limit_ma) begin
            run_next  = 1'b0;
            trip_next = 1'b1;
          end else begin
            target_next = tgt_upd;
            duty_next   = duty_upd;
            live_next   = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // state registers, updated as the beat leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      run_flag    <= 1'b0;
      duty_acc    <= '0;
      volt_target <= NOMINAL_RESET;
      cmp_live    <= 1'b0;
    end else if (go2) begin
      run_flag    <= run_next;
      duty_acc    <= duty_next;
      volt_target <= target_next;
      cmp_live    <= live_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (go2) begin
      s2.enabled  <= run_next;
      s2.tripped  <= trip_next;
      s2.duty     <= duty_next;
      s2.target   <= target_next;
      s2.cmp_live <= live_next;
    end
  end

  // compares: q = duty / 6250 = (duty >> 1) / 3125 by reciprocal
  assign prod_cmp = 39'(s2.duty[19:1]) * 39'(RECIP_3125);
  assign q_cmp    = prod_cmp[38:31];

  always_comb begin
    if (s2.cmp_live) begin
      cmp_main_next = (q_cmp >= CMP_TOP) ? '0 : (CMP_TOP - q_cmp);
      cmp_aux_next  = (q_cmp >= CMP_TOP_AUX) ? '0 : (CMP_TOP_AUX - q_cmp);
    end else begin
      cmp_main_next = CMP_TOP;
      cmp_aux_next  = CMP_TOP;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (v2 && adv3) begin
      enabled      <= s2.enabled;
      tripped      <= s2.tripped;
      duty_scaled  <= s2.duty;
      target_mv    <= s2.target;
      compare_main <= cmp_main_next;
      compare_aux  <= cmp_aux_next;
    end
  end

  assign out_valid = v3;

  // compare pair: aux one above main, both saturated, or both at the top
  assign cmp_pair_ok = (compare_aux == compare_main + 8'd1)
                    || (compare_aux == 8'd0 && compare_main == 8'd0)
                    || (compare_aux == CMP_TOP && compare_main == CMP_TOP);

  // checks
  `ASSERT_IMPLIES(a_trip_disables, clk, rst, out_valid && tripped, !enabled)
  `ASSERT_IMPLIES(a_cmp_pair, clk, rst, out_valid, cmp_pair_ok)
  `ASSERT_IMPLIES(a_run_rise, clk, rst, $rose(run_flag), $past(go2) && $past(s1.opcode) == OPC_ENABLE)

endmodule

`default_nettype wire
